// File: src/cdhq_pkg.sv
// cdhq_pkg: shared types, constants and lookup tables of the chroma dc
// hadamard / quantizer core
// no dependencies

package cdhq_pkg;

    // field and register widths
    localparam int DATA_W           = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int MODE_W           = 2;
    localparam int QP_W             = 6;
    localparam int QE_W             = 4;
    localparam int QM_W             = 3;
    localparam int SCALE_W          = 14;
    localparam int OFFSET_W         = 25;
    localparam int SHIFT_W          = 5;
    localparam int SHIFT_BASE       = 16;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = 6;

    // qp / 6 as a multiply by a reciprocal, exact for every 6-bit qp
    localparam int QP_DIV6_MUL      = 43;
    localparam int QP_DIV6_SHIFT    = 8;
    localparam int QP_MOD_BASE      = 6;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_XFORM_QUANT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_XFORM       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUANT       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_XFORM_ALT   = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QP   = 1'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] in0;
        logic signed [DATA_W-1:0] in1;
        logic signed [DATA_W-1:0] in2;
        logic signed [DATA_W-1:0] in3;
    } blk_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out0;
        logic signed [DATA_W-1:0] out1;
        logic signed [DATA_W-1:0] out2;
        logic signed [DATA_W-1:0] out3;
    } coef_t;

    // decoded configuration handed to the datapath
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [QE_W-1:0]   qe;
        logic [QM_W-1:0]   qm;
    } cfg_t;

    // quantizer scale per qp mod 6
    function automatic logic [SCALE_W-1:0] scale_lookup(input logic [QM_W-1:0] qm);
        logic [SCALE_W-1:0] s;
        unique case (qm)
            3'd0:    s = 14'd13107;
            3'd1:    s = 14'd11916;
            3'd2:    s = 14'd10082;
            3'd3:    s = 14'd9362;
            3'd4:    s = 14'd8192;
            3'd5:    s = 14'd7282;
            default: s = '0;
        endcase
        return s;
    endfunction

    // rounding offset 2*floor(2^(15+qe)/3) per qp / 6
    function automatic logic [OFFSET_W-1:0] offset_lookup(input logic [QE_W-1:0] qe);
        logic [OFFSET_W-1:0] f;
        unique case (qe)
            4'd0:    f = 25'd21844;
            4'd1:    f = 25'd43690;
            4'd2:    f = 25'd87380;
            4'd3:    f = 25'd174762;
            4'd4:    f = 25'd349524;
            4'd5:    f = 25'd699050;
            4'd6:    f = 25'd1398100;
            4'd7:    f = 25'd2796202;
            4'd8:    f = 25'd5592404;
            4'd9:    f = 25'd11184810;
            4'd10:   f = 25'd22369620;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// File: src/cdhq_cfg_regs.sv
// cdhq_cfg_regs: mode and qp registers, qp split into qp/6 and qp mod 6
// depends on cdhq_pkg

module cdhq_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [cdhq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cdhq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output cdhq_pkg::cfg_t                     cfg
);

    logic [cdhq_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [cdhq_pkg::QE_W-1:0]   qe_reg, qe_next;
    logic [cdhq_pkg::QM_W-1:0]   qm_reg, qm_next;

    logic [cdhq_pkg::QP_W-1:0]   qp_val;
    logic [2*cdhq_pkg::QP_W-1:0] div_prod;
    logic [cdhq_pkg::QP_W-1:0]   qe_times6;
    logic [cdhq_pkg::QP_W-1:0]   rem;

    assign qp_val    = cfg_data[cdhq_pkg::QP_W-1:0];
    assign div_prod  = qp_val * cdhq_pkg::QP_W'(cdhq_pkg::QP_DIV6_MUL);
    assign qe_times6 = cdhq_pkg::QP_W'(div_prod[cdhq_pkg::QP_DIV6_SHIFT +: cdhq_pkg::QE_W])
                       * cdhq_pkg::QP_W'(cdhq_pkg::QP_MOD_BASE);
    assign rem       = qp_val - qe_times6;

    always_comb
    begin
        mode_next = mode_reg;
        qe_next   = qe_reg;
        qm_next   = qm_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                cdhq_pkg::REG_MODE:
                begin
                    mode_next = cfg_data[cdhq_pkg::MODE_W-1:0];
                end
                cdhq_pkg::REG_QP:
                begin
                    qe_next = div_prod[cdhq_pkg::QP_DIV6_SHIFT +: cdhq_pkg::QE_W];
                    qm_next = rem[cdhq_pkg::QM_W-1:0];
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // reset qp is 1: qp/6 = 0, qp mod 6 = 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cdhq_pkg::MODE_XFORM_QUANT;
            qe_reg   <= '0;
            qm_reg   <= cdhq_pkg::QM_W'(1);
        end
        else
        begin
            mode_reg <= mode_next;
            qe_reg   <= qe_next;
            qm_reg   <= qm_next;
        end
    end

    assign cfg.mode = mode_reg;
    assign cfg.qe   = qe_reg;
    assign cfg.qm   = qm_reg;

endmodule

// File: src/cdhq_quant.sv
// cdhq_quant: sign-magnitude quantizer for one coefficient
// depends on cdhq_pkg

module cdhq_quant #(
    parameter int IN_W = cdhq_pkg::SAMPLE_WIDTH_DEF + 2
) (
    input  logic signed [IN_W-1:0]            x,
    input  logic [cdhq_pkg::QE_W-1:0]         qe,
    input  logic [cdhq_pkg::QM_W-1:0]         qm,
    output logic signed [cdhq_pkg::DATA_W-1:0] q
);

    localparam int PROD_W = IN_W + cdhq_pkg::SCALE_W;
    localparam int SUM_W  = ((PROD_W > cdhq_pkg::OFFSET_W) ? PROD_W : cdhq_pkg::OFFSET_W) + 1;

    logic                              neg;
    logic [IN_W-1:0]                   mag;
    logic [PROD_W-1:0]                 prod;
    logic [SUM_W-1:0]                  sum;
    logic [cdhq_pkg::SHIFT_W-1:0]      shamt;
    logic [SUM_W-1:0]                  shifted;
    logic [cdhq_pkg::DATA_W-1:0]       q_mag;

    assign neg     = x[IN_W-1];
    assign mag     = neg ? (~x + IN_W'(1)) : x;
    assign prod    = PROD_W'(mag) * PROD_W'(cdhq_pkg::scale_lookup(qm));
    assign sum     = SUM_W'(prod) + SUM_W'(cdhq_pkg::offset_lookup(qe));
    assign shamt   = cdhq_pkg::SHIFT_W'(cdhq_pkg::SHIFT_BASE) + cdhq_pkg::SHIFT_W'(qe);
    assign shifted = sum >> shamt;
    assign q_mag   = shifted[cdhq_pkg::DATA_W-1:0];
    // sign restored modulo 2^16
    assign q       = neg ? (~q_mag + cdhq_pkg::DATA_W'(1)) : q_mag;

endmodule

// File: src/cdhq_datapath.sv
// cdhq_datapath: 2x2 hadamard, mode select and four quantizer lanes
// depends on cdhq_pkg and cdhq_quant

module cdhq_datapath #(
    parameter int SAMPLE_WIDTH = cdhq_pkg::SAMPLE_WIDTH_DEF
) (
    input  cdhq_pkg::blk_t  blk,
    input  cdhq_pkg::cfg_t  cfg,
    output cdhq_pkg::coef_t coef
);

    localparam int Y_W  = SAMPLE_WIDTH + 2;
    localparam int EXT_W = Y_W + cdhq_pkg::DATA_W;

    logic [cdhq_pkg::DATA_W-1:0] raw  [4];
    logic signed [Y_W-1:0]       x    [4];
    logic signed [Y_W-1:0]       y    [4];
    logic signed [Y_W-1:0]       q_in [4];
    logic signed [cdhq_pkg::DATA_W-1:0] q_out [4];
    logic [cdhq_pkg::DATA_W-1:0] res  [4];
    logic signed [Y_W-1:0]       r0, r1, t0, t1;

    assign raw[0] = blk.in0;
    assign raw[1] = blk.in1;
    assign raw[2] = blk.in2;
    assign raw[3] = blk.in3;

    assign r0   = x[0] + x[1];
    assign r1   = x[0] - x[1];
    assign t0   = x[2] + x[3];
    assign t1   = x[2] - x[3];
    assign y[0] = r0 + t0;
    assign y[1] = r1 + t1;
    assign y[2] = r0 - t0;
    assign y[3] = r1 - t1;

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        logic [SAMPLE_WIDTH-1:0] lo;
        logic [EXT_W-1:0]        y_ext;

        // sample is the low bits of the field, sign extended
        assign lo      = raw[i][SAMPLE_WIDTH-1:0];
        assign x[i]    = {{2{lo[SAMPLE_WIDTH-1]}}, lo};
        assign q_in[i] = (cfg.mode == cdhq_pkg::MODE_QUANT) ? x[i] : y[i];
        assign y_ext   = {{cdhq_pkg::DATA_W{y[i][Y_W-1]}}, y[i]};

        cdhq_quant #(
            .IN_W (Y_W)
        ) u_quant (
            .x  (q_in[i]),
            .qe (cfg.qe),
            .qm (cfg.qm),
            .q  (q_out[i])
        );

        always_comb
        begin
            unique case (cfg.mode)
                cdhq_pkg::MODE_XFORM_QUANT: res[i] = q_out[i];
                cdhq_pkg::MODE_QUANT:       res[i] = q_out[i];
                cdhq_pkg::MODE_XFORM:       res[i] = y_ext[cdhq_pkg::DATA_W-1:0];
                cdhq_pkg::MODE_XFORM_ALT:   res[i] = y_ext[cdhq_pkg::DATA_W-1:0];
                default:                    res[i] = y_ext[cdhq_pkg::DATA_W-1:0];
            endcase
        end
    end

    assign coef.out0 = res[0];
    assign coef.out1 = res[1];
    assign coef.out2 = res[2];
    assign coef.out3 = res[3];

endmodule

// File: src/chroma_dc_hadamard_quant_core.sv
// chroma_dc_hadamard_quant_core: top level of the chroma dc 2x2 hadamard
// and quantizer; depends on cdhq_pkg, cdhq_cfg_regs, cdhq_datapath

// one 2x2 block of signed chroma dc samples comes in per word on blk and
// one word of four coefficients leaves on coef. mode 0 runs the 2x2
// hadamard and then quantizes, mode 1 (and the unused code 3) gives the
// hadamard only, mode 2 quantizes the four samples directly. quantization
// is (|x|*scale[qp mod 6] + 2*floor(2^(15+qp/6)/3)) >> (16+qp/6) with the
// sign put back, and every result is wrapped to 16 bits. a word moves at a
// clock edge where valid is high and stall is low. the block takes one word
// per cycle while coef_stall is low; a word passes the input register and
// then the result register, with the hadamard, one multiplier per lane and
// the rounding shift between them. the input register doubles as a skid
// stage: when empty it takes a new block while a finished word waits on
// coef_stall. cfg_ready is always high; write mode and qp only while the
// core is empty. qp above 51 still follows the same formula.

module chroma_dc_hadamard_quant_core #(
    parameter int SAMPLE_WIDTH = cdhq_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // block input channel
    input  logic                             blk_valid,
    output logic                             blk_stall,
    input  cdhq_pkg::blk_t                   blk,

    // coefficient output channel
    output logic                             coef_valid,
    input  logic                             coef_stall,
    output cdhq_pkg::coef_t                  coef,

    // register write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cdhq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cdhq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    cdhq_pkg::cfg_t  cfg;
    cdhq_pkg::coef_t coef_comb;

    // input stage
    logic            s1_valid_reg, s1_valid_next;
    cdhq_pkg::blk_t  s1_blk_reg;

    // result stage
    logic            out_valid_reg, out_valid_next;
    cdhq_pkg::coef_t out_reg;

    logic            blk_accept;
    logic            out_load;
    logic            s1_advance;

    // registers are always writable
    assign cfg_ready = 1'b1;

    cdhq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cdhq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .blk  (s1_blk_reg),
        .cfg  (cfg),
        .coef (coef_comb)
    );

    // result register can load when empty or being drained this cycle
    assign out_load   = !out_valid_reg || !coef_stall;
    assign s1_advance = s1_valid_reg && out_load;
    // input register only blocks when it is full and cannot move on
    assign blk_stall  = s1_valid_reg && !out_load;
    assign blk_accept = blk_valid && !blk_stall;

    always_comb
    begin
        if (blk_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (blk_accept)
        begin
            s1_blk_reg <= blk;
        end
        if (s1_advance)
        begin
            out_reg <= coef_comb;
        end
    end

    assign coef_valid = out_valid_reg;
    assign coef       = out_reg;

endmodule

// File: src/cdhq_checker.sv
// cdhq_checker: port-level assertions for chroma_dc_hadamard_quant_core
// depends on cdhq_pkg; bound to the top level at the end of this file

module cdhq_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             blk_valid,
    input  logic                             blk_stall,
    input  logic                             coef_valid,
    input  logic                             coef_stall,
    input  cdhq_pkg::coef_t                  coef
);

    logic blk_acc;

    assign blk_acc = blk_valid && !blk_stall;

    // a stalled result word stays and holds its value
    a_coef_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (coef_valid && coef_stall) |=> (coef_valid && $stable(coef)))
        else $error("coef word dropped or changed while stalled");

    // input stalls only when the result register is full and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        blk_stall |-> (coef_valid && coef_stall))
        else $error("blk stalled without a blocked result");

    // a new result appears only for a block taken through the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(coef_valid) |-> $past(blk_acc, 2))
        else $error("result word without a matching block");

    // with nothing taken and nothing shown, nothing appears
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (!coef_valid && !$past(blk_acc)) |=> !coef_valid)
        else $error("result word invented");

endmodule

bind chroma_dc_hadamard_quant_core cdhq_checker u_cdhq_checker (.*);
